@@ rtl/core/pwmasc_pkg.sv @@
// Shared types and constants for the PWM audio sample conditioner.
// Used by pwmasc_ctrl, pwmasc_dp and the top level; depends on nothing.
`default_nettype none

package pwmasc_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned FADE_W   = 12;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned RES_W    = 4;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 7;

  // Default fade-in ramp length in samples
  localparam int unsigned FADE_LEN_DEF = 800;

  // Divide-by-constant datapath: dividend width, reciprocal width and shift
  localparam int unsigned DIV_W     = 28;
  localparam int unsigned RCP_W     = 29;
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned PROD_W    = DIV_W + RCP_W;

  // Volume divisor and its reciprocal
  localparam logic [RCP_W-1:0] VOL_DIV = RCP_W'(100);
  localparam logic [RCP_W-1:0] RCP_VOL = RCP_W'((64'(1) << DIV_SHIFT) / 100);

  // Offsets for two's complement samples
  localparam logic [15:0] OFS_16 = 16'h7fff;
  localparam logic [7:0]  OFS_8  = 8'h7f;

  // Volume and resolution limits
  localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(100);
  localparam logic [RES_W-1:0] RES_MIN = RES_W'(8);
  localparam logic [RES_W-1:0] RES_MAX = RES_W'(12);

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH16 = 2'd0,
    CFG_SIGNED  = 2'd1,
    CFG_VOLUME  = 2'd2,
    CFG_RES     = 2'd3
  } cfg_idx_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input word and update fade ramp
    logic mul_vol;   // dividend = sample * volume
    logic mul_fade;  // dividend = sample * fade count
    logic rcp;       // estimate quotient by reciprocal multiply
    logic fix;       // correct quotient, write back to sample
    logic sel_fade;  // divisor is the fade length, else 100
    logic out_load;  // move result into output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scaled;    // current word is scaled by the fade ramp
    logic out_busy;  // output register holds a word that is not taken this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pwmasc_ctrl.sv @@
// Sequencer for the conditioner: steps the shared multiplier through
// volume and fade scaling. Depends on pwmasc_pkg.
`default_nettype none

module pwmasc_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  pwmasc_pkg::dp_stat_t    stat,
  output pwmasc_pkg::ctrl_cmd_t   cmd
);
  import pwmasc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MULV = 8'b0000_0010,
    ST_RCPV = 8'b0000_0100,
    ST_FIXV = 8'b0000_1000,
    ST_MULF = 8'b0001_0000,
    ST_RCPF = 8'b0010_0000,
    ST_FIXF = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Accept a word only when idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MULV;
        end
      end
      ST_MULV: begin
        cmd.mul_vol = 1'b1;
        state_nxt   = ST_RCPV;
      end
      ST_RCPV: begin
        cmd.rcp   = 1'b1;
        state_nxt = ST_FIXV;
      end
      ST_FIXV: begin
        cmd.fix   = 1'b1;
        state_nxt = stat.scaled ? ST_MULF : ST_DONE;
      end
      ST_MULF: begin
        cmd.mul_fade = 1'b1;
        state_nxt    = ST_RCPF;
      end
      ST_RCPF: begin
        cmd.rcp      = 1'b1;
        cmd.sel_fade = 1'b1;
        state_nxt    = ST_FIXF;
      end
      ST_FIXF: begin
        cmd.fix      = 1'b1;
        cmd.sel_fade = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted word always starts with the volume multiply
  a_load_then_mulv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_MULV))
    else $error("accepted word did not start volume scaling");

  // A result is never moved out while the output register is occupied
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("output register overwritten");

  // Fade steps run only for words the ramp scales
  a_fade_only_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIXV) && !stat.scaled |=> (state_r == ST_DONE))
    else $error("fade scaling run on an unscaled word");

endmodule

`default_nettype wire

@@ rtl/core/pwmasc_dp.sv @@
// Datapath for the conditioner: configuration registers, fade ramp state,
// shared multiplier, divide-by-constant correction and output register.
// Depends on pwmasc_pkg.
`default_nettype none

module pwmasc_dp #(
  parameter int unsigned FADE_LEN = pwmasc_pkg::FADE_LEN_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [pwmasc_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire  [pwmasc_pkg::CFG_DW-1:0]       cfg_wdata,
  input  wire  [pwmasc_pkg::SAMPLE_W-1:0]     in_sample_bits,
  input  wire                                 in_restart_fade,
  input  wire                                 in_last_in_block,
  input  pwmasc_pkg::ctrl_cmd_t               cmd,
  output pwmasc_pkg::dp_stat_t                stat,
  input  wire                                 out_stall,
  output logic                                out_valid,
  output logic [pwmasc_pkg::LEVEL_W-1:0]      out_pwm_level,
  output logic                                out_fading,
  output logic                                out_last_out
);
  import pwmasc_pkg::*;

  localparam logic [FADE_W-1:0] FADE_LEN_C = FADE_W'(FADE_LEN);
  localparam logic [RCP_W-1:0]  FADE_DIV   = RCP_W'(FADE_LEN);
  localparam logic [RCP_W-1:0]  RCP_FADE   = RCP_W'((64'(1) << DIV_SHIFT) / FADE_LEN);

  // Configuration
  logic                 width16_r;
  logic                 signed_r;
  logic [VOL_W-1:0]     volume_r;
  logic [RES_W-1:0]     res_r;

  // Fade ramp state
  logic [FADE_W-1:0]    fade_count_r, fade_count_nxt;
  logic                 fade_active_r, fade_active_nxt;

  // Working registers
  logic [SAMPLE_W-1:0]  v_r, v_nxt;
  logic [DIV_W-1:0]     x_r, x_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [FADE_W-1:0]    fc_r, fc_nxt;
  logic                 scaled_r, scaled_nxt;
  logic                 last_r, last_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic                 fading_r, fading_nxt;
  logic                 last_out_r, last_out_nxt;

  // Shared multiplier operands
  logic [DIV_W-1:0]     mul_a;
  logic [RCP_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;
  logic [RCP_W-1:0]     div_d;
  logic [DIV_W-1:0]     rem;
  logic                 rem_ge;

  // Input word after masking and offset
  logic [SAMPLE_W-1:0]  v_in;
  logic                 act_eff;
  logic [FADE_W-1:0]    cnt_eff;
  logic [FADE_W-1:0]    cnt_new;
  logic                 scaled_in;

  // Write configuration, clamping volume and resolution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width16_r <= 1'b0;
      signed_r  <= 1'b0;
      volume_r  <= VOL_MAX;
      res_r     <= RES_MIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH16: width16_r <= cfg_wdata[0];
        CFG_SIGNED:  signed_r  <= cfg_wdata[0];
        CFG_VOLUME:  volume_r  <= (cfg_wdata > VOL_MAX) ? VOL_MAX : cfg_wdata;
        CFG_RES: begin
          if (cfg_wdata[RES_W-1:0] < RES_MIN) begin
            res_r <= RES_MIN;
          end else if (cfg_wdata[RES_W-1:0] > RES_MAX) begin
            res_r <= RES_MAX;
          end else begin
            res_r <= cfg_wdata[RES_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Mask and offset the incoming sample; work out the ramp for it
  always_comb begin
    if (width16_r) begin
      v_in = signed_r ? (in_sample_bits + OFS_16) : in_sample_bits;
    end else begin
      v_in = {8'd0, signed_r ? (in_sample_bits[7:0] + OFS_8) : in_sample_bits[7:0]};
    end
    act_eff   = in_restart_fade | fade_active_r;
    cnt_eff   = in_restart_fade ? '0 : fade_count_r;
    scaled_in = act_eff && (cnt_eff < FADE_LEN_C);
    cnt_new   = scaled_in ? FADE_W'(cnt_eff + 1'b1) : cnt_eff;
  end

  // Pick multiplier operands for the current step
  always_comb begin
    div_d = cmd.sel_fade ? FADE_DIV : VOL_DIV;
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_vol) begin
      mul_a = DIV_W'(v_r);
      mul_b = RCP_W'(volume_r);
    end else if (cmd.mul_fade) begin
      mul_a = DIV_W'(v_r);
      mul_b = RCP_W'(fc_r);
    end else if (cmd.rcp) begin
      mul_a = x_r;
      mul_b = cmd.sel_fade ? RCP_FADE : RCP_VOL;
    end else if (cmd.fix) begin
      mul_a = q_r;
      mul_b = div_d;
    end
    prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    rem    = x_r - prod[DIV_W-1:0];
    rem_ge = (RCP_W'(rem) >= div_d);
  end

  // Advance working registers, ramp state and output register
  always_comb begin
    v_nxt           = v_r;
    x_nxt           = x_r;
    q_nxt           = q_r;
    fc_nxt          = fc_r;
    scaled_nxt      = scaled_r;
    last_nxt        = last_r;
    fade_count_nxt  = fade_count_r;
    fade_active_nxt = fade_active_r;
    level_nxt       = level_r;
    fading_nxt      = fading_r;
    last_out_nxt    = last_out_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (cmd.load) begin
      v_nxt           = v_in;
      fc_nxt          = cnt_eff;
      scaled_nxt      = scaled_in;
      last_nxt        = in_last_in_block;
      fade_count_nxt  = cnt_new;
      fade_active_nxt = act_eff && (cnt_new < FADE_LEN_C);
    end
    if (cmd.mul_vol || cmd.mul_fade) begin
      x_nxt = prod[DIV_W-1:0];
    end
    if (cmd.rcp) begin
      q_nxt = prod[DIV_SHIFT +: DIV_W];
    end
    if (cmd.fix) begin
      v_nxt = SAMPLE_W'(q_r + DIV_W'(rem_ge));
    end
    if (cmd.out_load) begin
      if (width16_r) begin
        level_nxt = LEVEL_W'(v_r >> (5'd16 - {1'b0, res_r}));
      end else begin
        level_nxt = LEVEL_W'({4'd0, v_r[7:0]} << (res_r - RES_MIN));
      end
      fading_nxt    = scaled_r;
      last_out_nxt  = last_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_count_r  <= '0;
      fade_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      fade_count_r  <= fade_count_nxt;
      fade_active_r <= fade_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    x_r        <= x_nxt;
    q_r        <= q_nxt;
    fc_r       <= fc_nxt;
    scaled_r   <= scaled_nxt;
    last_r     <= last_nxt;
    level_r    <= level_nxt;
    fading_r   <= fading_nxt;
    last_out_r <= last_out_nxt;
  end

  assign stat.scaled   = scaled_r;
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid     = out_valid_r;
  assign out_pwm_level = level_r;
  assign out_fading    = fading_r;
  assign out_last_out  = last_out_r;

  // A running ramp never sits at or past its end
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fade_active_r |-> (fade_count_r < FADE_LEN_C))
    else $error("fade ramp ran past its length");

  // Reciprocal estimate is at most one short, so one correction suffices
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> (RCP_W'(rem) < (div_d << 1)))
    else $error("quotient estimate out of correction range");

  // A scaled word always has its ramp position below the length
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_fade |-> (fc_r < FADE_LEN_C))
    else $error("fade factor out of range");

endmodule

`default_nettype wire

@@ rtl/core/pwm_audio_sample_conditioner.sv @@
// PWM audio sample conditioner: one sample word in, one duty level word out.
// Each word is scaled by volume, then by the fade ramp while it scales, each a
// divide-by-constant on the single shared multiplier; a new word is taken only
// once the last one has moved into the output register. The output register
// lets the next word be taken while a result waits. Synchronous active-low
// reset restores default configuration and clears the ramp and output valid.
`default_nettype none

module pwm_audio_sample_conditioner #(
  parameter int unsigned FADE_LEN = pwmasc_pkg::FADE_LEN_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [pwmasc_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire  [pwmasc_pkg::CFG_DW-1:0]    cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [pwmasc_pkg::SAMPLE_W-1:0]  in_sample_bits,
  input  wire                              in_restart_fade,
  input  wire                              in_last_in_block,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pwmasc_pkg::LEVEL_W-1:0]   out_pwm_level,
  output logic                             out_fading,
  output logic                             out_last_out
);
  import pwmasc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  pwmasc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  pwmasc_dp #(
    .FADE_LEN (FADE_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_sample_bits   (in_sample_bits),
    .in_restart_fade  (in_restart_fade),
    .in_last_in_block (in_last_in_block),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pwm_level    (out_pwm_level),
    .out_fading       (out_fading),
    .out_last_out     (out_last_out)
  );

endmodule

`default_nettype wire

@@ tb/sv/pwmasc_level_check_pkg.sv @@
// Scoreboard for the PWM audio sample conditioner bench: predicts duty levels.
// Depends on pwmasc_pkg for field widths, limits, offsets and register indexes.
package pwmasc_level_check_pkg;
  import pwmasc_pkg::*;

  // One expected result word
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               fading;
    logic               last;
  } duty_word_t;

  class duty_scoreboard;
    logic               wide16;
    logic               offset_on;
    logic [VOL_W-1:0]   volume;
    logic [RES_W-1:0]   res_bits;
    logic [FADE_W-1:0]  ramp_count;
    logic               ramp_on;
    duty_word_t         due_q[$];
    int                 errors;

    // Hold the state that the block has after reset
    function new();
      wide16     = 1'b0;
      offset_on  = 1'b0;
      volume     = VOL_MAX;
      res_bits   = RES_MIN;
      ramp_count = '0;
      ramp_on    = 1'b0;
      errors     = 0;
    endfunction

    // Track a register write, clamping as the block does
    function void write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] data);
      logic [RES_W-1:0] r;
      r = data[RES_W-1:0];
      case (idx)
        CFG_WIDTH16: wide16 = data[0];
        CFG_SIGNED:  offset_on = data[0];
        CFG_VOLUME:  volume = (data[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : data[VOL_W-1:0];
        CFG_RES: begin
          if (r < RES_MIN) r = RES_MIN;
          if (r > RES_MAX) r = RES_MAX;
          res_bits = r;
        end
        default: ;
      endcase
    endfunction

    // Work out the duty level for an accepted sample word and queue it
    function void note_sample(logic [SAMPLE_W-1:0] bits, logic restart, logic last);
      logic [31:0] mask;
      logic [31:0] v;
      duty_word_t  w;
      mask = wide16 ? 32'h0000_ffff : 32'h0000_00ff;
      v    = 32'(bits) & mask;
      if (restart) begin
        ramp_on    = 1'b1;
        ramp_count = '0;
      end
      // offset two's complement samples, wrapping at the sample width
      if (offset_on) v = (v + (wide16 ? 32'(OFS_16) : 32'(OFS_8))) & mask;
      v = (v * 32'(volume) / 32'(VOL_DIV)) & mask;
      w.fading = 1'b0;
      // scale by the fade-in ramp and advance it
      if (ramp_on && ramp_count < FADE_LEN_DEF) begin
        v = (v * 32'(ramp_count) / FADE_LEN_DEF) & mask;
        ramp_count = ramp_count + 1'b1;
        w.fading = 1'b1;
      end
      if (ramp_on && ramp_count >= FADE_LEN_DEF) ramp_on = 1'b0;
      // narrow to or widen to the PWM resolution
      if (wide16) w.level = LEVEL_W'(v >> (5'd16 - 5'(res_bits)));
      else        w.level = LEVEL_W'(v << (res_bits - 4'd8));
      w.last = last;
      due_q.push_back(w);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Print one mismatch line (first hundred only) and count it
    task report(string what);
      if (errors < 100) $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Compare a result word with the oldest expectation
    task check_level(logic [LEVEL_W-1:0] level, logic fading, logic last);
      duty_word_t w;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected word level=%0d fading=%0b last=%0b",
                         level, fading, last));
      end else begin
        w = due_q.pop_front();
        if (level !== w.level)
          report($sformatf("pwm_level got %0d want %0d", level, w.level));
        if (fading !== w.fading)
          report($sformatf("fading got %0b want %0b", fading, w.fading));
        if (last !== w.last)
          report($sformatf("last_out got %0b want %0b", last, w.last));
      end
    endtask
  endclass

endpackage

@@ tb/sv/tb_pwm_audio_sample_conditioner.sv @@
// Bench for pwm_audio_sample_conditioner: directed and random sample words
// under several configurations and idling patterns, checked by a scoreboard.
// Depends on pwmasc_pkg and pwmasc_level_check_pkg.
module tb_pwm_audio_sample_conditioner;
  import pwmasc_pkg::*;
  import pwmasc_level_check_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_PHASE  = 3;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_bits = '0;
  logic                in_restart_fade = 1'b0;
  logic                in_last_in_block = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LEVEL_W-1:0]  out_pwm_level;
  logic                out_fading;
  logic                out_last_out;

  duty_scoreboard sb;
  int             tx_pct = 0;
  int             rx_pct = 0;
  int             phase_id = 0;
  bit             hold_arm = 1'b0;
  bit             hold_done = 1'b0;
  int             hold_left = 0;
  int             cycles = 0;

  pwm_audio_sample_conditioner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_bits   (in_sample_bits),
    .in_restart_fade  (in_restart_fade),
    .in_last_in_block (in_last_in_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pwm_level    (out_pwm_level),
    .out_fading       (out_fading),
    .out_last_out     (out_last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_we) sb.write_reg(cfg_idx_t'(cfg_addr), cfg_wdata);
  end

  // Predict each accepted input word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_sample(in_sample_bits, in_restart_fade, in_last_in_block);
  end

  // Check each accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_level(out_pwm_level, out_fading, out_last_out);
  end

  // Drive the receiver stall: one long hold once, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_TX:   begin tx_pct = 53; rx_pct = 0;  end
      IDLE_RX:   begin tx_pct = 0;  rx_pct = 53; end
      IDLE_BOTH: begin tx_pct = 22; rx_pct = 22; end
      default:   begin tx_pct = 0;  rx_pct = 0;  end
    endcase
  endtask

  // Offer one word, with random gaps ahead, and hold it until taken
  task automatic send_word(input logic [SAMPLE_W-1:0] bits, input logic restart,
                           input logic last);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_bits   <= bits;
    in_restart_fade  <= restart;
    in_last_in_block <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DW-1:0] w16, input logic [CFG_DW-1:0] sgn,
                            input logic [CFG_DW-1:0] vol, input logic [CFG_DW-1:0] res);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_WIDTH16;
    cfg_wdata <= w16;
    @(posedge clk);
    cfg_addr  <= CFG_SIGNED;
    cfg_wdata <= sgn;
    @(posedge clk);
    cfg_addr  <= CFG_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_addr  <= CFG_RES;
    cfg_wdata <= res;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly random bits, with corner values mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(7) != 0) return SAMPLE_W'($urandom);
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h7fff;
      3:       return 16'h8000;
      4:       return 16'h007f;
      default: return 16'h0080;
    endcase
  endfunction

  // Field extremes, block marks, ramp start and a restart mid-ramp
  task automatic directed_words();
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hffff, 1'b0, 1'b0);
    send_word(16'h00ff, 1'b0, 1'b1);
    send_word(16'hff00, 1'b0, 1'b0);
    send_word(16'h007f, 1'b0, 1'b0);
    send_word(16'h0080, 1'b0, 1'b1);
    send_word(16'h7fff, 1'b1, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'hffff, 1'b0, 1'b0);
    send_word(16'hffff, 1'b1, 1'b0);
    send_word(16'haaaa, 1'b0, 1'b0);
    send_word(16'h5555, 1'b0, 1'b1);
  endtask

  // Configure, then stream write blocks of random length, with random restarts when restart_odds is nonzero
  task automatic run_phase(input logic w16, input logic sgn, input logic [VOL_W-1:0] vol,
                           input logic [3:0] res, input idle_mode_t mode,
                           input int n_words, input int restart_odds,
                           input bit ramp_at_start);
    int   blk_left;
    logic restart;
    logic last;
    drain_results();
    phase_id = phase_id + 1;
    write_regs({6'($urandom_range(63)), w16}, {6'($urandom_range(63)), sgn}, vol,
               {3'($urandom_range(7)), res});
    set_idling(mode);
    blk_left = $urandom_range(32, 1);
    for (int i = 0; i < n_words; i++) begin
      restart = (i == 0 && ramp_at_start) ||
                (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
      last     = (blk_left == 1);
      blk_left = last ? $urandom_range(32, 1) : blk_left - 1;
      if (phase_id == HOLD_PHASE && i == 20) hold_arm = 1'b1;
      send_word(pick_sample(), restart, last);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings, then 16-bit signed at widest PWM
    set_idling(IDLE_NONE);
    directed_words();
    drain_results();
    write_regs(7'h01, 7'h01, 7'd100, 7'd12);
    directed_words();

    // random phases; the last three run one ramp through to its end
    run_phase(1'b1, 1'b1, 7'd100, 4'd12, IDLE_NONE, 100, 10, 1'b0);
    run_phase(1'b0, 1'b0, 7'd0,   4'd8,  IDLE_TX,   100, 10, 1'b0);
    run_phase(1'b0, 1'b1, 7'd127, 4'd15, IDLE_RX,   100, 12, 1'b0);
    run_phase(1'b1, 1'b0, 7'd55,  4'd0,  IDLE_BOTH, 100, 12, 1'b0);
    run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 7'($urandom_range(127)),
              4'($urandom_range(15)), IDLE_BOTH, 100, 6, 1'b0);
    run_phase(1'b1, 1'b1, 7'd100, 4'd10, IDLE_NONE, 300, 0, 1'b1);
    run_phase(1'b0, 1'b0, 7'd73,  4'd11, IDLE_RX,   300, 0, 1'b0);
    run_phase(1'b1, 1'b0, 7'd101, 4'd9,  IDLE_TX,   250, 0, 1'b0);

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pwmasc_pkg.sv
rtl/core/pwmasc_ctrl.sv
rtl/core/pwmasc_dp.sv
rtl/core/pwm_audio_sample_conditioner.sv
tb/sv/pwmasc_level_check_pkg.sv
tb/sv/tb_pwm_audio_sample_conditioner.sv
